FILE: hw/rtl/rbim_pkg.sv
// Shared definitions for the ring buffer index manager.
// Command and status codes, default sizes and the register map.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package rbim_pkg;

	// Default number of storage slots.
	localparam int DEF_MAX_SLOTS = 1024;

	// Capacity value that reset loads, before saturation to the slot count.
	localparam int CAP_RESET_VAL = 1024;

	// Configuration port layout.
	localparam int APB_DATA_W = 32;
	localparam int APB_ADDR_W = 3;
	localparam int REG_IDX_LSB = 2;

	localparam logic REG_CAPACITY = 1'b0;

	// Commands, carried in tuser on the input stream.
	localparam logic [1:0] CMD_RESET   = 2'd0;
	localparam logic [1:0] CMD_PRODUCE = 2'd1;
	localparam logic [1:0] CMD_CONSUME = 2'd2;
	localparam logic [1:0] CMD_PEEK    = 2'd3;

	// Result status, carried in tuser on the output stream.
	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_NO_SPACE  = 2'd1;
	localparam logic [1:0] ST_NO_DATA   = 2'd2;
	localparam logic [1:0] ST_OUT_RANGE = 2'd3;

endpackage

`default_nettype wire

FILE: hw/rtl/rbim_cfg.sv
// Configuration register block of the ring buffer index manager.
// Holds the saturated ring capacity behind an APB-style port; uses rbim_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rbim_cfg
	import rbim_pkg::*;
#(
	parameter int MAX_SLOTS = DEF_MAX_SLOTS,
	parameter int CNT_W     = $clog2(MAX_SLOTS + 1)
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  psel,
	input  wire logic                  penable,
	input  wire logic                  pwrite,
	input  wire logic [APB_ADDR_W-1:0] paddr,
	input  wire logic [APB_DATA_W-1:0] pwdata,
	output logic      [APB_DATA_W-1:0] prdata,
	output logic                       pready,
	output logic      [CNT_W-1:0]      capacity,
	output logic                       ring_clear
);

	localparam int CAP_RST_INT = (CAP_RESET_VAL > MAX_SLOTS) ? MAX_SLOTS : CAP_RESET_VAL;
	localparam logic [CNT_W-1:0] CAP_RST = CNT_W'(CAP_RST_INT);
	localparam logic [CNT_W-1:0] CAP_MAX = CNT_W'(MAX_SLOTS);
	localparam logic [CNT_W-1:0] CAP_MIN = CNT_W'(1);

	logic [CNT_W-1:0] capacity_q;
	logic [CNT_W-1:0] wr_value;
	logic [CNT_W-1:0] wr_clamped;
	logic             reg_sel;
	logic             wr_en;

	assign pready  = 1'b1;
	assign reg_sel = (paddr[APB_ADDR_W-1:REG_IDX_LSB] == REG_CAPACITY);
	assign wr_en   = psel && penable && pwrite && pready && reg_sel;

	assign wr_value = pwdata[CNT_W-1:0];

	always_comb begin
		if (wr_value == '0) begin
			wr_clamped = CAP_MIN;
		end else if (wr_value > CAP_MAX) begin
			wr_clamped = CAP_MAX;
		end else begin
			wr_clamped = wr_value;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q <= CAP_RST;
		end else if (wr_en) begin
			capacity_q <= wr_clamped;
		end
	end

	always_comb begin
		if (reg_sel) begin
			prdata = APB_DATA_W'(capacity_q);
		end else begin
			prdata = '0;
		end
	end

	// A capacity write restarts the ring, so the pointers are cleared with it.
	assign capacity   = capacity_q;
	assign ring_clear = wr_en;

endmodule

`default_nettype wire

FILE: hw/rtl/rbim_core.sv
// Pointer state and command logic of the ring buffer index manager.
// Keeps read slot, write slot and fill count; uses rbim_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rbim_core
	import rbim_pkg::*;
#(
	parameter int MAX_SLOTS = DEF_MAX_SLOTS,
	parameter int SLOT_W    = $clog2(MAX_SLOTS),
	parameter int CNT_W     = $clog2(MAX_SLOTS + 1)
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic [CNT_W-1:0]  capacity,
	input  wire logic              ring_clear,
	input  wire logic              advance,
	input  wire logic [1:0]        command,
	input  wire logic [CNT_W-1:0]  amount,
	output logic      [1:0]        status,
	output logic      [SLOT_W-1:0] peek_slot,
	output logic      [SLOT_W-1:0] read_slot,
	output logic      [SLOT_W-1:0] write_slot,
	output logic      [CNT_W-1:0]  fill_count,
	output logic      [CNT_W-1:0]  vacant_count,
	output logic      [CNT_W-1:0]  write_run,
	output logic      [CNT_W-1:0]  read_run
);

	logic [SLOT_W-1:0] rd_ptr_q;
	logic [SLOT_W-1:0] wr_ptr_q;
	logic [CNT_W-1:0]  held_q;

	logic [SLOT_W-1:0] rd_ptr_n;
	logic [SLOT_W-1:0] wr_ptr_n;
	logic [CNT_W-1:0]  held_n;

	logic [CNT_W-1:0]  move_base;
	logic [CNT_W-1:0]  move_step;
	logic [CNT_W-1:0]  move_room;
	logic [CNT_W-1:0]  move_sum;
	logic [CNT_W-1:0]  free_now;
	logic [CNT_W-1:0]  wr_room;
	logic [CNT_W-1:0]  rd_room;

	// One wrap unit serves all moving commands: a produce moves the write slot,
	// a consume or peek moves from the read slot. The step never exceeds
	// the capacity, so one subtract folds a full turn and one more wraps.
	always_comb begin
		if (command == CMD_PRODUCE) begin
			move_base = CNT_W'(wr_ptr_q);
		end else begin
			move_base = CNT_W'(rd_ptr_q);
		end
		if (amount >= capacity) begin
			move_step = amount - capacity;
		end else begin
			move_step = amount;
		end
		move_room = capacity - move_base;
		if (move_step >= move_room) begin
			move_sum = move_step - move_room;
		end else begin
			move_sum = move_base + move_step;
		end
	end

	assign free_now = capacity - held_q;

	always_comb begin
		rd_ptr_n  = rd_ptr_q;
		wr_ptr_n  = wr_ptr_q;
		held_n    = held_q;
		status    = ST_OK;
		peek_slot = '0;
		unique case (command)
			CMD_RESET: begin
				rd_ptr_n = '0;
				wr_ptr_n = '0;
				held_n   = '0;
			end
			CMD_PRODUCE: begin
				if (amount > free_now) begin
					status = ST_NO_SPACE;
				end else begin
					wr_ptr_n = move_sum[SLOT_W-1:0];
					held_n   = held_q + amount;
				end
			end
			CMD_CONSUME: begin
				if (amount > held_q) begin
					status = ST_NO_DATA;
				end else begin
					rd_ptr_n = move_sum[SLOT_W-1:0];
					held_n   = held_q - amount;
				end
			end
			CMD_PEEK: begin
				if (amount >= held_q) begin
					status = ST_OUT_RANGE;
				end else begin
					peek_slot = move_sum[SLOT_W-1:0];
				end
			end
			default: begin
				status = ST_OK;
			end
		endcase
	end

	// Reported values describe the state after this beat.
	assign read_slot    = rd_ptr_n;
	assign write_slot   = wr_ptr_n;
	assign fill_count   = held_n;
	assign vacant_count = capacity - held_n;
	assign wr_room      = capacity - CNT_W'(wr_ptr_n);
	assign rd_room      = capacity - CNT_W'(rd_ptr_n);
	assign write_run    = (vacant_count < wr_room) ? vacant_count : wr_room;
	assign read_run     = (held_n < rd_room) ? held_n : rd_room;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_ptr_q <= '0;
			wr_ptr_q <= '0;
			held_q   <= '0;
		end else if (ring_clear) begin
			rd_ptr_q <= '0;
			wr_ptr_q <= '0;
			held_q   <= '0;
		end else if (advance) begin
			rd_ptr_q <= rd_ptr_n;
			wr_ptr_q <= wr_ptr_n;
			held_q   <= held_n;
		end
	end

endmodule

`default_nettype wire

FILE: hw/rtl/ring_buffer_index_manager.sv
// Ring buffer index manager: one command beat in, one result beat out.
// An accepted command is registered, then its result beat is held in the result register.
// Throughput: one command per cycle unless a result beat stalls; the input register,
// the pointer update and the result register form a single pass with no iteration.
// Reset: asynchronous, clears the pointers and fill count and loads capacity 1024
// (saturated to MAX_SLOTS). Depends on rbim_pkg, rbim_cfg and rbim_core.
`timescale 1ns / 1ps
`default_nettype none

module ring_buffer_index_manager
	import rbim_pkg::*;
#(
	parameter int MAX_SLOTS = DEF_MAX_SLOTS,
	parameter int SLOT_W    = $clog2(MAX_SLOTS),
	parameter int CNT_W     = $clog2(MAX_SLOTS + 1),
	parameter int IN_W      = ((CNT_W + 7) / 8) * 8,
	parameter int OUT_W     = ((3 * SLOT_W + 4 * CNT_W + 7) / 8) * 8
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  s_tvalid,
	output logic                       s_tready,
	// s_tdata: amount
	input  wire logic [IN_W-1:0]       s_tdata,
	// s_tuser: command
	input  wire logic [1:0]            s_tuser,
	output logic                       m_tvalid,
	input  wire logic                  m_tready,
	// m_tdata: peek_slot, read_slot, write_slot, fill_count, vacant_count,
	// write_run, read_run
	output logic      [OUT_W-1:0]      m_tdata,
	// m_tuser: status
	output logic      [1:0]            m_tuser,
	input  wire logic                  psel,
	input  wire logic                  penable,
	input  wire logic                  pwrite,
	input  wire logic [APB_ADDR_W-1:0] paddr,
	input  wire logic [APB_DATA_W-1:0] pwdata,
	output logic      [APB_DATA_W-1:0] prdata,
	output logic                       pready
);

	localparam int PAD_W = OUT_W - (3 * SLOT_W + 4 * CNT_W);

	logic [CNT_W-1:0]  capacity;
	logic              ring_clear;

	logic              valid_s1;
	logic [1:0]        command_s1;
	logic [CNT_W-1:0]  amount_s1;
	logic              advance;

	logic [1:0]        status_c;
	logic [SLOT_W-1:0] peek_c;
	logic [SLOT_W-1:0] rd_slot_c;
	logic [SLOT_W-1:0] wr_slot_c;
	logic [CNT_W-1:0]  fill_c;
	logic [CNT_W-1:0]  free_c;
	logic [CNT_W-1:0]  wr_run_c;
	logic [CNT_W-1:0]  rd_run_c;

	logic              out_valid_q;
	logic [1:0]        status_q;
	logic [SLOT_W-1:0] peek_q;
	logic [SLOT_W-1:0] rd_slot_q;
	logic [SLOT_W-1:0] wr_slot_q;
	logic [CNT_W-1:0]  fill_q;
	logic [CNT_W-1:0]  free_q;
	logic [CNT_W-1:0]  wr_run_q;
	logic [CNT_W-1:0]  rd_run_q;

	rbim_cfg #(
		.MAX_SLOTS (MAX_SLOTS),
		.CNT_W     (CNT_W)
	) u_cfg (
		.clk        (clk),
		.arst_n     (arst_n),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.prdata     (prdata),
		.pready     (pready),
		.capacity   (capacity),
		.ring_clear (ring_clear)
	);

	// The command register drains into the result register whenever the
	// result register is empty or its beat is being taken.
	assign advance  = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			command_s1 <= s_tuser;
			amount_s1  <= s_tdata[CNT_W-1:0];
		end
	end

	rbim_core #(
		.MAX_SLOTS (MAX_SLOTS),
		.SLOT_W    (SLOT_W),
		.CNT_W     (CNT_W)
	) u_core (
		.clk          (clk),
		.arst_n       (arst_n),
		.capacity     (capacity),
		.ring_clear   (ring_clear),
		.advance      (advance),
		.command      (command_s1),
		.amount       (amount_s1),
		.status       (status_c),
		.peek_slot    (peek_c),
		.read_slot    (rd_slot_c),
		.write_slot   (wr_slot_c),
		.fill_count   (fill_c),
		.vacant_count (free_c),
		.write_run    (wr_run_c),
		.read_run     (rd_run_c)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			status_q  <= status_c;
			peek_q    <= peek_c;
			rd_slot_q <= rd_slot_c;
			wr_slot_q <= wr_slot_c;
			fill_q    <= fill_c;
			free_q    <= free_c;
			wr_run_q  <= wr_run_c;
			rd_run_q  <= rd_run_c;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = status_q;
	assign m_tdata  = {PAD_W'(0), rd_run_q, wr_run_q, free_q, fill_q,
		wr_slot_q, rd_slot_q, peek_q};

	// Fill and free space always add up to the capacity.
	a_fill_free_sum: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> ((CNT_W + 1)'(fill_q) + (CNT_W + 1)'(free_q)) == (CNT_W + 1)'(capacity))
		else $error("fill and free count do not add up to the capacity");

	// Both pointers stay inside the ring.
	a_slots_in_ring: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (CNT_W'(rd_slot_q) < capacity) && (CNT_W'(wr_slot_q) < capacity))
		else $error("pointer beyond the ring capacity");

	// A rejected command reports no peek slot.
	a_reject_no_peek: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && (status_q != ST_OK)) |-> (peek_q == '0))
		else $error("peek slot set on a rejected command");

	// Runs never exceed the counts they are bounded by.
	a_runs_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (wr_run_q <= free_q) && (rd_run_q <= fill_q))
		else $error("contiguous run larger than its count");

endmodule

`default_nettype wire

FILE: dv/tb_ring_buffer_index_manager.sv
// Testbench for ring_buffer_index_manager: streams commands, predicts each
// result beat with its own ring model and checks every field.
// Depends on rbim_pkg and the RTL of the block only.
`timescale 1ns / 1ps

module tb_ring_buffer_index_manager;
	import rbim_pkg::*;

	localparam int IN_W        = 16;
	localparam int OUT_W       = 80;
	localparam int RES_W       = 74;
	localparam int SINK_HOLD   = 400;
	localparam int CYCLE_LIMIT = 300000;
	localparam int PHASE_ITEMS = 45;

	localparam logic [APB_ADDR_W-1:0] ADDR_CAPACITY = {REG_CAPACITY, 2'b00};
	localparam logic [APB_ADDR_W-1:0] ADDR_UNUSED   = 3'd4;

	typedef struct {
		logic [1:0]  cmd;
		logic [10:0] amount;
	} ring_cmd_t;

	// Status sits in the low bits so that {m_tdata, m_tuser} maps straight onto it.
	typedef struct packed {
		logic [10:0] read_run;
		logic [10:0] write_run;
		logic [10:0] vacant_count;
		logic [10:0] fill_count;
		logic [9:0]  write_slot;
		logic [9:0]  read_slot;
		logic [9:0]  peek_slot;
		logic [1:0]  status;
	} ring_result_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [IN_W-1:0]       s_tdata = '0;
	logic [1:0]            s_tuser = CMD_RESET;
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [OUT_W-1:0]      m_tdata;
	logic [1:0]            m_tuser;
	logic                  psel = 1'b0;
	logic                  penable = 1'b0;
	logic                  pwrite = 1'b0;
	logic [APB_ADDR_W-1:0] paddr = '0;
	logic [APB_DATA_W-1:0] pwdata = '0;
	logic [APB_DATA_W-1:0] prdata;
	logic                  pready;

	ring_cmd_t    pending_cmds[$];
	ring_result_t expected_results[$];

	// Predicted ring state.
	int unsigned cap_model = DEF_MAX_SLOTS;
	int unsigned rd_model = 0;
	int unsigned wr_model = 0;
	int unsigned fill_model = 0;

	// Fill level as planned by the stimulus generator.
	int unsigned plan_cap = DEF_MAX_SLOTS;
	int unsigned plan_fill = 0;

	int          err_count = 0;
	int          cycle_count = 0;
	bit          no_gaps = 1'b0;
	int          hold_req = 0;
	int          hold_seen = 0;
	int          hold_left = 0;
	int          src_gap = 0;
	int          sink_gap = 0;
	ring_cmd_t   drive_beat;
	ring_result_t want_res;
	ring_result_t got_res;

	ring_buffer_index_manager u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	always #10 clk = ~clk;

	function automatic int unsigned saturate_capacity(logic [10:0] value);
		if (value == 0)
			return 1;
		if (value > DEF_MAX_SLOTS)
			return DEF_MAX_SLOTS;
		return value;
	endfunction

	// Wrap by compare and subtract; a step of the whole capacity is a no-op.
	function automatic int unsigned step_index(int unsigned idx, int unsigned stp);
		if (stp >= cap_model)
			stp -= cap_model;
		if (stp >= cap_model - idx)
			return stp - (cap_model - idx);
		return idx + stp;
	endfunction

	function automatic int unsigned min_of(int unsigned a, int unsigned b);
		return (a < b) ? a : b;
	endfunction

	function automatic void advance_ring(logic [1:0] cmd, logic [10:0] amt);
		ring_result_t res;
		int unsigned a;
		int unsigned free_slots;
		res = '0;
		res.status = ST_OK;
		a = amt;
		case (cmd)
			CMD_RESET: begin
				rd_model = 0;
				wr_model = 0;
				fill_model = 0;
			end
			CMD_PRODUCE: begin
				if (a > cap_model - fill_model) begin
					res.status = ST_NO_SPACE;
				end else begin
					wr_model = step_index(wr_model, a);
					fill_model += a;
				end
			end
			CMD_CONSUME: begin
				if (a > fill_model) begin
					res.status = ST_NO_DATA;
				end else begin
					rd_model = step_index(rd_model, a);
					fill_model -= a;
				end
			end
			default: begin
				if (a >= fill_model)
					res.status = ST_OUT_RANGE;
				else
					res.peek_slot = 10'(step_index(rd_model, a));
			end
		endcase
		free_slots = cap_model - fill_model;
		res.read_slot = 10'(rd_model);
		res.write_slot = 10'(wr_model);
		res.fill_count = 11'(fill_model);
		res.vacant_count = 11'(free_slots);
		res.write_run = 11'(min_of(free_slots, cap_model - wr_model));
		res.read_run = 11'(min_of(fill_model, cap_model - rd_model));
		expected_results.push_back(res);
	endfunction

	function automatic void check_field(string name, int unsigned want, int unsigned got);
		if (want != got) begin
			$error("%s mismatch: expected %0d, got %0d", name, want, got);
			err_count++;
		end
	endfunction

	// Mostly short gaps, now and then a long one.
	function automatic int idle_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 96)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	// Command driver.
	always @(posedge clk) begin
		if (s_tvalid && s_tready)
			advance_ring(s_tuser, s_tdata[10:0]);
		if (!s_tvalid || s_tready) begin
			if (src_gap > 0) begin
				src_gap--;
				s_tvalid <= 1'b0;
			end else if (pending_cmds.size() > 0) begin
				drive_beat = pending_cmds.pop_front();
				s_tvalid <= 1'b1;
				s_tuser <= drive_beat.cmd;
				s_tdata <= {{(IN_W - 11){1'b0}}, drive_beat.amount};
				src_gap = no_gaps ? 0 : idle_len();
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// Result monitor and sink-side ready.
	always @(posedge clk) begin
		if (m_tvalid && m_tready) begin
			if (expected_results.size() == 0) begin
				$error("result beat with no expected result");
				err_count++;
			end else begin
				want_res = expected_results.pop_front();
				got_res = {m_tdata[RES_W-1:0], m_tuser};
				check_field("status", want_res.status, got_res.status);
				check_field("peek_slot", want_res.peek_slot, got_res.peek_slot);
				check_field("read_slot", want_res.read_slot, got_res.read_slot);
				check_field("write_slot", want_res.write_slot, got_res.write_slot);
				check_field("fill_count", want_res.fill_count, got_res.fill_count);
				check_field("vacant_count", want_res.vacant_count, got_res.vacant_count);
				check_field("write_run", want_res.write_run, got_res.write_run);
				check_field("read_run", want_res.read_run, got_res.read_run);
			end
		end
		if (hold_seen != hold_req) begin
			hold_seen = hold_req;
			hold_left = SINK_HOLD;
		end
		if (hold_left > 0) begin
			hold_left--;
			m_tready <= 1'b0;
		end else if (sink_gap > 0) begin
			sink_gap--;
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
			sink_gap = no_gaps ? 0 : idle_len();
		end
	end

	function automatic void queue_cmd(logic [1:0] cmd, int unsigned amt);
		ring_cmd_t c;
		c.cmd = cmd;
		c.amount = 11'(amt);
		pending_cmds.push_back(c);
	endfunction

	// Mostly legal moves with random sizes, plus edge sizes and rejected requests.
	task automatic plan_items(int n);
		int r;
		int v;
		int unsigned room;
		int unsigned amt;
		for (int i = 0; i < n; i++) begin
			r = $urandom_range(0, 99);
			v = $urandom_range(0, 9);
			room = plan_cap - plan_fill;
			if (r < 3) begin
				queue_cmd(CMD_RESET, $urandom_range(0, DEF_MAX_SLOTS));
				plan_fill = 0;
			end else if (r < 40) begin
				if (v < 7)
					amt = $urandom_range(0, room);
				else if (v == 7)
					amt = room;
				else if (v == 8)
					amt = min_of(room + 1, DEF_MAX_SLOTS);
				else
					amt = $urandom_range(0, DEF_MAX_SLOTS);
				if (amt <= room)
					plan_fill += amt;
				queue_cmd(CMD_PRODUCE, amt);
			end else if (r < 75) begin
				if (v < 7)
					amt = $urandom_range(0, plan_fill);
				else if (v == 7)
					amt = plan_fill;
				else if (v == 8)
					amt = min_of(plan_fill + 1, DEF_MAX_SLOTS);
				else
					amt = $urandom_range(0, DEF_MAX_SLOTS);
				if (amt <= plan_fill)
					plan_fill -= amt;
				queue_cmd(CMD_CONSUME, amt);
			end else begin
				if (plan_fill > 0 && v < 7)
					amt = $urandom_range(0, plan_fill - 1);
				else if (v == 7)
					amt = plan_fill;
				else
					amt = $urandom_range(0, DEF_MAX_SLOTS);
				queue_cmd(CMD_PEEK, amt);
			end
		end
	endtask

	task automatic wait_drained();
		@(negedge clk);
		while (pending_cmds.size() > 0 || s_tvalid || expected_results.size() > 0)
			@(negedge clk);
	endtask

	task automatic cfg_write(logic [APB_ADDR_W-1:0] addr, logic [APB_DATA_W-1:0] data);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		// The register takes the write at this edge; a capacity write restarts the ring.
		if (addr == ADDR_CAPACITY) begin
			cap_model = saturate_capacity(data[10:0]);
			rd_model = 0;
			wr_model = 0;
			fill_model = 0;
		end
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	int unsigned phase_caps [9] = '{0, 2047, 1, 2, 7, 1023, 100, 1024, 37};

	initial begin
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed sequence at the reset capacity of 1024.
		queue_cmd(CMD_CONSUME, 0);
		queue_cmd(CMD_CONSUME, 1);
		queue_cmd(CMD_PEEK, 0);
		queue_cmd(CMD_PRODUCE, 0);
		queue_cmd(CMD_PRODUCE, 1024);
		queue_cmd(CMD_PRODUCE, 1);
		queue_cmd(CMD_PEEK, 1023);
		queue_cmd(CMD_PEEK, 1024);
		queue_cmd(CMD_CONSUME, 1000);
		queue_cmd(CMD_PRODUCE, 1000);
		queue_cmd(CMD_PEEK, 100);
		queue_cmd(CMD_CONSUME, 1024);
		queue_cmd(CMD_CONSUME, 1);
		queue_cmd(CMD_PRODUCE, 1000);
		queue_cmd(CMD_PEEK, 999);
		queue_cmd(CMD_RESET, 1024);
		queue_cmd(CMD_PRODUCE, 3);
		queue_cmd(CMD_PEEK, 2);
		queue_cmd(CMD_CONSUME, 3);
		queue_cmd(CMD_PEEK, 0);
		queue_cmd(CMD_RESET, 0);

		for (int i = 0; i < 9; i++) begin
			wait_drained();
			no_gaps = (i == 2 || i == 5);
			// Long sink stall while the source streams without gaps.
			if (i == 5)
				hold_req++;
			cfg_write(ADDR_CAPACITY, phase_caps[i]);
			plan_cap = saturate_capacity(11'(phase_caps[i]));
			plan_fill = 0;
			plan_items(PHASE_ITEMS);
			if (i == 3) begin
				// A write to an unmapped register must not disturb the ring.
				wait_drained();
				cfg_write(ADDR_UNUSED, 32'd5);
				plan_items(20);
			end
		end

		wait_drained();
		repeat (8) @(posedge clk);
		if (err_count == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule

FILE: ring_buffer_index_manager.f
hw/rtl/rbim_pkg.sv
hw/rtl/rbim_cfg.sv
hw/rtl/rbim_core.sv
hw/rtl/ring_buffer_index_manager.sv
dv/tb_ring_buffer_index_manager.sv
